// ===== rtl/scrc_pkg.sv =====
// shared constants and types for the serial crc generator
package scrc_pkg;

    localparam int REM_W      = 32;
    localparam int MAX_DEGREE = 32;
    localparam int DEG_LIMIT  = (MAX_DEGREE < REM_W) ? MAX_DEGREE : REM_W;
    localparam int DEG_W      = 6;
    localparam int IDX_W      = $clog2(REM_W);
    localparam int CFG_IDX_W  = 8;
    localparam int TDATA_W    = 8;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] REG_CRC_DEGREE    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_GENERATOR_LOW = CFG_IDX_W'(1);

    localparam logic [DEG_W-1:0] DEGREE_RESET    = DEG_W'(3);
    localparam logic [REM_W-1:0] GENERATOR_RESET = REM_W'(3);

    // one queued request: message bit plus, on the last bit, the finished remainder
    typedef struct packed {
        logic             data_bit;
        logic             last_bit;
        logic [REM_W-1:0] check;
        logic [IDX_W-1:0] deg_m1;
    } scrc_entry_t;

endpackage

// ===== rtl/serial_crc_generator.sv =====
// top level of the bit-serial crc sender
//
//  channel   direction  payload
//  cfg       in         cfg_index (register), cfg_data (value)
//  s_*       in         tdata[0] data_bit, tlast last_bit
//  m_*       out        tdata[0] code_bit, tuser[0] is_check, tlast end_of_codeword
//
// one message bit is taken per cycle while the queue has room; the remainder update is one shift and xor
// a last bit holds the output side while the check bits shift out
// a four-entry request queue lets the input keep flowing while check bits drain
// reset restores degree 3 and generator x^3+x+1, clears the remainder and the queue
// m_tready low stalls the back end (output register and check shifting) and, once the queue fills, s_tready
module serial_crc_generator
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [scrc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [scrc_pkg::REM_W-1:0]      cfg_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [scrc_pkg::TDATA_W-1:0]    s_tdata,   // [0] data_bit, rest zero
    input  logic                            s_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [scrc_pkg::TDATA_W-1:0]    m_tdata,   // [0] code_bit, rest zero
    output logic [0:0]                      m_tuser,   // [0] is_check
    output logic                            m_tlast
);

    logic                  push;
    logic                  pop;
    logic                  full;
    logic                  empty;
    scrc_pkg::scrc_entry_t push_entry;
    scrc_pkg::scrc_entry_t pop_entry;
    logic                  code_bit;
    logic                  is_check;

    scrc_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .data_bit   (s_tdata[0]),
        .s_tlast    (s_tlast),
        .fifo_full  (full),
        .push       (push),
        .push_entry (push_entry)
    );

    scrc_fifo u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (full),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .empty      (empty)
    );

    scrc_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .empty     (empty),
        .pop_entry (pop_entry),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .code_bit  (code_bit),
        .is_check  (is_check),
        .m_tlast   (m_tlast)
    );

    assign m_tdata = {{(scrc_pkg::TDATA_W-1){1'b0}}, code_bit};
    assign m_tuser = is_check;

endmodule

// ===== rtl/scrc_front.sv =====
// front end: configuration registers, request accept and remainder update
module scrc_front
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [scrc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [scrc_pkg::REM_W-1:0]      cfg_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic                            data_bit,
    input  logic                            s_tlast,
    input  logic                            fifo_full,
    output logic                            push,
    output scrc_pkg::scrc_entry_t           push_entry
);

    logic [scrc_pkg::DEG_W-1:0] crc_degree_reg;
    logic [scrc_pkg::DEG_W-1:0] crc_degree_next;
    logic [scrc_pkg::REM_W-1:0] generator_low_reg;
    logic [scrc_pkg::REM_W-1:0] generator_low_next;
    logic [scrc_pkg::REM_W-1:0] remainder_reg;
    logic [scrc_pkg::REM_W-1:0] remainder_next;

    logic [scrc_pkg::DEG_W-1:0] deg_eff;
    logic [scrc_pkg::IDX_W-1:0] deg_m1;
    logic [scrc_pkg::REM_W-1:0] mask;
    logic [scrc_pkg::REM_W-1:0] rem_m;
    logic [scrc_pkg::REM_W-1:0] rem_upd;
    logic                       feedback;

    assign cfg_ready = 1'b1;
    assign s_tready  = !fifo_full;
    assign push      = s_tvalid && !fifo_full;

    // clamp degree into 1 .. limit
    always_comb
    begin
        priority if (crc_degree_reg == '0)
        begin
            deg_eff = scrc_pkg::DEG_W'(1);
        end
        else if (crc_degree_reg > scrc_pkg::DEG_W'(scrc_pkg::DEG_LIMIT))
        begin
            deg_eff = scrc_pkg::DEG_W'(scrc_pkg::DEG_LIMIT);
        end
        else
        begin
            deg_eff = crc_degree_reg;
        end
    end

    assign deg_m1 = scrc_pkg::IDX_W'(deg_eff - scrc_pkg::DEG_W'(1));
    // a shift by the full width leaves zero, so degree 32 gives all ones
    assign mask   = ~({scrc_pkg::REM_W{1'b1}} << deg_eff);
    assign rem_m  = remainder_reg & mask;

    always_comb
    begin
        feedback = data_bit ^ rem_m[deg_m1];
        rem_upd  = (rem_m << 1) & mask;
        if (feedback)
        begin
            rem_upd = rem_upd ^ (generator_low_reg & mask);
        end
    end

    always_comb
    begin
        push_entry.data_bit = data_bit;
        push_entry.last_bit = s_tlast;
        push_entry.check    = rem_upd;
        push_entry.deg_m1   = deg_m1;
    end

    always_comb
    begin
        crc_degree_next    = crc_degree_reg;
        generator_low_next = generator_low_reg;
        remainder_next     = remainder_reg;
        if (cfg_valid)
        begin
            if (cfg_index == scrc_pkg::REG_CRC_DEGREE)
            begin
                crc_degree_next = cfg_data[scrc_pkg::DEG_W-1:0];
            end
            else if (cfg_index == scrc_pkg::REG_GENERATOR_LOW)
            begin
                generator_low_next = cfg_data;
            end
        end
        if (push)
        begin
            remainder_next = s_tlast ? '0 : rem_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_degree_reg    <= scrc_pkg::DEGREE_RESET;
            generator_low_reg <= scrc_pkg::GENERATOR_RESET;
            remainder_reg     <= '0;
        end
        else
        begin
            crc_degree_reg    <= crc_degree_next;
            generator_low_reg <= generator_low_next;
            remainder_reg     <= remainder_next;
        end
    end

endmodule

// ===== rtl/scrc_fifo.sv =====
// short request queue between front and back ends
module scrc_fifo
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  scrc_pkg::scrc_entry_t push_entry,
    output logic                  full,
    input  logic                  pop,
    output scrc_pkg::scrc_entry_t pop_entry,
    output logic                  empty
);

    scrc_pkg::scrc_entry_t slot_reg [scrc_pkg::FIFO_DEPTH];

    logic [scrc_pkg::FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [scrc_pkg::FIFO_PTR_W-1:0] wr_ptr_next;
    logic [scrc_pkg::FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [scrc_pkg::FIFO_PTR_W-1:0] rd_ptr_next;
    logic [scrc_pkg::FIFO_CNT_W-1:0] count_reg;
    logic [scrc_pkg::FIFO_CNT_W-1:0] count_next;

    assign full      = (count_reg == scrc_pkg::FIFO_CNT_W'(scrc_pkg::FIFO_DEPTH));
    assign empty     = (count_reg == '0);
    assign pop_entry = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + scrc_pkg::FIFO_PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + scrc_pkg::FIFO_PTR_W'(1);
        end
        unique case ({push, pop})
            2'b10:   count_next = count_reg + scrc_pkg::FIFO_CNT_W'(1);
            2'b01:   count_next = count_reg - scrc_pkg::FIFO_CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/scrc_back.sv =====
// back end: emits message bits and serializes check bits into the output register
module scrc_back
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  empty,
    input  scrc_pkg::scrc_entry_t pop_entry,
    output logic                  pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic                  code_bit,
    output logic                  is_check,
    output logic                  m_tlast
);

    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic                       out_bit_reg;
    logic                       out_bit_next;
    logic                       out_check_reg;
    logic                       out_check_next;
    logic                       out_last_reg;
    logic                       out_last_next;
    logic                       chk_active_reg;
    logic                       chk_active_next;
    logic [scrc_pkg::REM_W-1:0] chk_rem_reg;
    logic [scrc_pkg::REM_W-1:0] chk_rem_next;
    logic [scrc_pkg::IDX_W-1:0] chk_idx_reg;
    logic [scrc_pkg::IDX_W-1:0] chk_idx_next;
    logic                       load;

    assign m_tvalid = out_valid_reg;
    assign code_bit = out_bit_reg;
    assign is_check = out_check_reg;
    assign m_tlast  = out_last_reg;

    assign load = !out_valid_reg || m_tready;
    assign pop  = load && !chk_active_reg && !empty;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_bit_next    = out_bit_reg;
        out_check_next  = out_check_reg;
        out_last_next   = out_last_reg;
        chk_active_next = chk_active_reg;
        chk_rem_next    = chk_rem_reg;
        chk_idx_next    = chk_idx_reg;
        if (load)
        begin
            priority if (chk_active_reg)
            begin
                // check bits go out most significant first
                out_valid_next = 1'b1;
                out_bit_next   = chk_rem_reg[chk_idx_reg];
                out_check_next = 1'b1;
                out_last_next  = (chk_idx_reg == '0);
                chk_idx_next   = chk_idx_reg - scrc_pkg::IDX_W'(1);
                if (chk_idx_reg == '0)
                begin
                    chk_active_next = 1'b0;
                end
            end
            else if (!empty)
            begin
                out_valid_next = 1'b1;
                out_bit_next   = pop_entry.data_bit;
                out_check_next = 1'b0;
                out_last_next  = 1'b0;
                if (pop_entry.last_bit)
                begin
                    chk_active_next = 1'b1;
                    chk_rem_next    = pop_entry.check;
                    chk_idx_next    = pop_entry.deg_m1;
                end
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_bit_reg   <= out_bit_next;
        out_check_reg <= out_check_next;
        out_last_reg  <= out_last_next;
        chk_rem_reg   <= chk_rem_next;
        chk_idx_reg   <= chk_idx_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            chk_active_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            chk_active_reg <= chk_active_next;
        end
    end

endmodule

// ===== rtl/scrc_checker.sv =====
// port-level assertions for the serial crc generator and their bind
module scrc_checker
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [scrc_pkg::TDATA_W-1:0] m_tdata,
    input logic [0:0]                   m_tuser,
    input logic                         m_tlast,
    input logic                         s_tvalid,
    input logic                         s_tready
);

    // a stalled result keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("output changed while stalled");

    // the codeword ends only on an appended check bit
    a_last_is_check: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tuser[0])
        else $error("end of codeword on a message bit");

    // padding bits above code_bit stay zero
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[scrc_pkg::TDATA_W-1:1] == '0))
        else $error("nonzero tdata padding");

    // the beat after an accepted message bit ends the codeword only on a check bit
    a_check_follows: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tuser[0] && !m_tlast |=> !m_tvalid || !m_tlast
            || m_tuser[0])
        else $error("message bit marked as end of codeword");

    // the input side is held off only while a result waits at the output
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && !s_tready |-> m_tvalid)
        else $error("input stalled with no pending result");

endmodule

bind serial_crc_generator scrc_checker u_scrc_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready)
);

// ===== tb/sv/testbench.sv =====
// self-checking testbench for the bit-serial crc sender
`timescale 1ns / 1ps

class codeword_scoreboard;

    typedef struct packed {
        logic code_bit;
        logic is_check;
        logic end_of_codeword;
    } code_bit_t;

    logic [scrc_pkg::DEG_W-1:0] degree_reg;
    logic [scrc_pkg::REM_W-1:0] poly_low;
    logic [scrc_pkg::REM_W-1:0] running_rem;
    code_bit_t                  codeword_q[$];
    int                         fails;

    function new();
        degree_reg  = scrc_pkg::DEGREE_RESET;
        poly_low    = scrc_pkg::GENERATOR_RESET;
        running_rem = '0;
        fails       = 0;
    endfunction

    function void write_config(logic [scrc_pkg::CFG_IDX_W-1:0] idx,
                               logic [scrc_pkg::REM_W-1:0] val);
        if (idx == scrc_pkg::REG_CRC_DEGREE)
            degree_reg = val[scrc_pkg::DEG_W-1:0];
        else if (idx == scrc_pkg::REG_GENERATOR_LOW)
            poly_low = val;
    endfunction

    // degree zero acts as one, oversize degrees saturate
    function int unsigned active_degree();
        int unsigned d;
        d = degree_reg;
        if (d < 1)
            d = 1;
        if (d > scrc_pkg::DEG_LIMIT)
            d = scrc_pkg::DEG_LIMIT;
        return d;
    endfunction

    function void note_message_bit(logic data_bit, logic last_bit);
        int unsigned d;
        logic [63:0] mask;
        logic [63:0] r;
        logic [63:0] g;
        logic        fb;
        code_bit_t   e;
        d    = active_degree();
        mask = (64'd1 << d) - 64'd1;
        r    = {32'b0, running_rem} & mask;
        g    = {32'b0, poly_low} & mask;
        fb   = data_bit ^ r[d-1];
        r    = (r << 1) & mask;
        if (fb)
            r = r ^ g;
        e.code_bit        = data_bit;
        e.is_check        = 1'b0;
        e.end_of_codeword = 1'b0;
        codeword_q.push_back(e);
        if (last_bit)
        begin
            for (int unsigned k = 0; k < d; k++)
            begin
                e.code_bit        = r[d-1-k];
                e.is_check        = 1'b1;
                e.end_of_codeword = (k == d - 1);
                codeword_q.push_back(e);
            end
            running_rem = '0;
        end
        else
        begin
            running_rem = r[31:0];
        end
    endfunction

    function void check_code_bit(logic code_bit, logic is_check, logic end_of_codeword);
        code_bit_t e;
        if (codeword_q.size() == 0)
        begin
            $error("unexpected result: code_bit %0d is_check %0d end_of_codeword %0d",
                   code_bit, is_check, end_of_codeword);
            fails++;
            return;
        end
        e = codeword_q.pop_front();
        if (e.code_bit !== code_bit)
        begin
            $error("code_bit mismatch: expected %0d, actual %0d", e.code_bit, code_bit);
            fails++;
        end
        if (e.is_check !== is_check)
        begin
            $error("is_check mismatch: expected %0d, actual %0d", e.is_check, is_check);
            fails++;
        end
        if (e.end_of_codeword !== end_of_codeword)
        begin
            $error("end_of_codeword mismatch: expected %0d, actual %0d",
                   e.end_of_codeword, end_of_codeword);
            fails++;
        end
    endfunction

    function int pending();
        return codeword_q.size();
    endfunction

endclass

module testbench;

    localparam int QUIET_LIMIT  = 1000;
    localparam int HOLD_CYCLES  = 120;
    localparam int RANDOM_ITEMS = 230;

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [scrc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [scrc_pkg::REM_W-1:0]     cfg_data  = '0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [scrc_pkg::TDATA_W-1:0]   s_tdata   = '0;   // [0] data_bit, rest zero
    logic                           s_tlast   = 1'b0;
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [scrc_pkg::TDATA_W-1:0]   m_tdata;          // [0] code_bit, rest zero
    logic [0:0]                     m_tuser;          // [0] is_check
    logic                           m_tlast;

    codeword_scoreboard board;
    int unsigned        src_idle_pct = 11;
    int unsigned        dst_idle_pct = 53;
    int unsigned        items_sent   = 0;
    int unsigned        stall_ask    = 0;
    int unsigned        stall_seen   = 0;
    int unsigned        hold_left    = 0;
    int unsigned        quiet_cycles = 0;

    serial_crc_generator i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always #10 clk = ~clk;

    // receiver: random back-pressure, plus long hold-offs on request
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (stall_ask != stall_seen)
        begin
            m_tready   <= 1'b0;
            hold_left  <= HOLD_CYCLES;
            stall_seen <= stall_ask;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= dst_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                board.write_config(cfg_index, cfg_data);
            if (s_tvalid && s_tready)
                board.note_message_bit(s_tdata[0], s_tlast);
            if (m_tvalid && m_tready)
                board.check_code_bit(m_tdata[0], m_tuser[0], m_tlast);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (cfg_valid && cfg_ready) || (s_tvalid && s_tready)
            || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic send_bit(input logic data_bit, input logic last_bit);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(scrc_pkg::TDATA_W-1){1'b0}}, data_bit};
        s_tlast  <= last_bit;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic send_bits(input int unsigned count, input logic ends_message);
        for (int unsigned i = 0; i < count; i++)
            send_bit(1'($urandom_range(1)), ends_message && (i == count - 1));
    endtask

    task automatic write_reg(input logic [scrc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [scrc_pkg::REM_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // wait until every expected code bit is out, then let the pipeline settle
    task automatic wait_codeword_done();
        s_tvalid <= 1'b0;
        repeat (2) @(posedge clk);
        while (board.pending() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_random_degree();
        logic [scrc_pkg::DEG_W-1:0] deg;
        if ($urandom_range(9) < 8)
            deg = scrc_pkg::DEG_W'($urandom_range(32, 1));
        else if ($urandom_range(1) == 0)
            deg = '0;
        else
            deg = scrc_pkg::DEG_W'($urandom_range(63, 33));
        // upper bits of the write word are not part of the register
        write_reg(scrc_pkg::REG_CRC_DEGREE,
                  ($urandom() & 32'hFFFF_FFC0) | scrc_pkg::REM_W'(deg));
    endtask

    initial
    begin
        int unsigned len;
        int unsigned split;
        int unsigned phase_end;
        board = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // reset setting: degree 3, x^3+x+1
        send_bit(1'b1, 1'b0);
        send_bit(1'b1, 1'b0);
        send_bit(1'b0, 1'b0);
        send_bit(1'b1, 1'b1);
        wait_codeword_done();
        // writes to unknown indexes change nothing
        write_reg(scrc_pkg::CFG_IDX_W'(2), $urandom());
        write_reg({scrc_pkg::CFG_IDX_W{1'b1}}, $urandom());
        send_bit(1'b1, 1'b0);
        send_bit(1'b0, 1'b1);
        wait_codeword_done();
        // degree zero acts as one, high generator bits ignored
        write_reg(scrc_pkg::REG_CRC_DEGREE, 32'hFFFF_FFC0);
        write_reg(scrc_pkg::REG_GENERATOR_LOW, 32'hFFFF_FFFF);
        send_bit(1'b1, 1'b0);
        send_bit(1'b1, 1'b1);
        wait_codeword_done();
        // oversize degree saturates, one-bit message
        write_reg(scrc_pkg::REG_CRC_DEGREE, 32'd63);
        write_reg(scrc_pkg::REG_GENERATOR_LOW, 32'h04C1_1DB7);
        send_bit(1'b1, 1'b1);
        wait_codeword_done();
        write_reg(scrc_pkg::REG_CRC_DEGREE, 32'd33);
        send_bit(1'b1, 1'b1);
        wait_codeword_done();
        write_reg(scrc_pkg::REG_CRC_DEGREE, 32'd32);
        write_reg(scrc_pkg::REG_GENERATOR_LOW, 32'h0000_0000);
        send_bit(1'b0, 1'b0);
        send_bit(1'b1, 1'b0);
        send_bit(1'b1, 1'b1);
        wait_codeword_done();
        // degree change in the middle of a message
        write_reg(scrc_pkg::REG_CRC_DEGREE, 32'd8);
        write_reg(scrc_pkg::REG_GENERATOR_LOW, 32'h0000_0007);
        send_bit(1'b1, 1'b0);
        send_bit(1'b0, 1'b0);
        send_bit(1'b1, 1'b0);
        wait_codeword_done();
        write_reg(scrc_pkg::REG_CRC_DEGREE, 32'd5);
        write_reg(scrc_pkg::REG_GENERATOR_LOW, 32'h0000_0005);
        send_bit(1'b1, 1'b0);
        send_bit(1'b1, 1'b1);
        wait_codeword_done();

        phase_end = items_sent;
        for (int ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0: begin src_idle_pct = 11; dst_idle_pct = 53; end
                1: begin src_idle_pct = 53; dst_idle_pct = 11; end
                default: begin src_idle_pct = 0; dst_idle_pct = 0; end
            endcase
            phase_end = phase_end + RANDOM_ITEMS / 3;
            if (ph != 1)
            begin
                // long receiver hold-off while the sender keeps pushing
                stall_ask <= stall_ask + 1;
                send_bits(24, 1'b1);
            end
            while (items_sent < phase_end)
            begin
                if ($urandom_range(99) < 40)
                begin
                    wait_codeword_done();
                    write_random_degree();
                    write_reg(scrc_pkg::REG_GENERATOR_LOW, $urandom());
                end
                len = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
                if (len > 1 && $urandom_range(9) == 0)
                begin
                    split = $urandom_range(len - 1, 1);
                    send_bits(split, 1'b0);
                    wait_codeword_done();
                    write_random_degree();
                    send_bits(len - split, 1'b1);
                end
                else
                begin
                    send_bits(len, 1'b1);
                end
            end
        end

        wait_codeword_done();
        repeat (10) @(posedge clk);
        if (board.fails == 0 && board.pending() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/scrc_pkg.sv
rtl/scrc_front.sv
rtl/scrc_fifo.sv
rtl/scrc_back.sv
rtl/serial_crc_generator.sv
rtl/scrc_checker.sv
tb/sv/testbench.sv
